>>> sv/assert_macros.svh
// Assertion macros shared by the flood alarm latch RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SFAL_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sfal assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SFAL_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sfal assertion failed");

`endif

>>> sv/sfal_pkg.sv
// Types and constants for the sustained flood alarm latch.
// Depends on nothing; imported by every module of the block.
package sfal_pkg;

    localparam int TIME_W      = 32;
    localparam int SUSTAIN_W   = 20;
    localparam int CFG_IDX_W   = 2;

    localparam int STROBE_PERIOD_DEF  = 200;
    localparam int STROBE_ON_TIME_DEF = 100;

    localparam logic [SUSTAIN_W-1:0] TRIGGER_RST = 20'd5000;
    localparam logic [SUSTAIN_W-1:0] CLEAR_RST   = 20'd60000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TRIGGER = 2'd0,
        CFG_CLEAR   = 2'd1
    } t_cfg_idx;

    typedef struct packed {
        logic [TIME_W-1:0] now_ms;
        logic              fwd_wet;
        logic              mid_wet;
        logic              low_volt_on;
    } t_in_item;

    typedef struct packed {
        logic flood_latched;
        logic strobe_active;
        logic led_level;
        logic restore_nav;
    } t_out_item;

    typedef struct packed {
        logic [SUSTAIN_W-1:0] trigger_sustain_ms;
        logic [SUSTAIN_W-1:0] clear_sustain_ms;
    } t_cfg;

    // Per-item flags produced by the latch update.
    typedef struct packed {
        logic latched;
        logic strobing;
        logic restore;
    } t_latch_res;

    // Load enables for the stages of the LED phase pipeline.
    typedef struct packed {
        logic s1;
        logic s2;
    } t_pipe_adv;

endpackage

>>> sv/sfal_cfg.sv
// Configuration registers of the flood alarm latch.
// Depends on sfal_pkg.
module sfal_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    input  logic [sfal_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [sfal_pkg::SUSTAIN_W-1:0]    i_cfg_data,
    output logic                              o_cfg_ready,
    output sfal_pkg::t_cfg                    o_cfg
);
    import sfal_pkg::*;

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.trigger_sustain_ms <= TRIGGER_RST;
            r_cfg.clear_sustain_ms   <= CLEAR_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_TRIGGER: r_cfg.trigger_sustain_ms <= i_cfg_data;
                CFG_CLEAR:   r_cfg.clear_sustain_ms   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

endmodule

>>> sv/sfal_latch.sv
// Wet/dry sustain timers, alarm latch and strobe edge tracking.
// Depends on sfal_pkg and assert_macros.svh.
`include "assert_macros.svh"
module sfal_latch (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  sfal_pkg::t_in_item    i_in,
    input  sfal_pkg::t_cfg        i_cfg,
    output sfal_pkg::t_latch_res  o_res
);
    import sfal_pkg::*;

    logic              r_latch;
    logic              r_wet_run;
    logic              r_dry_run;
    logic              r_prev_strobe;
    logic [TIME_W-1:0] r_wet_start;
    logic [TIME_W-1:0] r_dry_start;

    logic              n_latch;
    logic              n_wet_run;
    logic              n_dry_run;
    logic              n_prev_strobe;
    logic [TIME_W-1:0] n_wet_start;
    logic [TIME_W-1:0] n_dry_start;

    logic              wet;
    logic [TIME_W-1:0] wet_elapsed;
    logic [TIME_W-1:0] dry_elapsed;
    logic              strobing;

    always_comb begin
        wet = i_in.fwd_wet | i_in.mid_wet;
        // A timer that is not running starts now, so its elapsed time is zero.
        n_wet_start = r_wet_run ? r_wet_start : i_in.now_ms;
        n_dry_start = r_dry_run ? r_dry_start : i_in.now_ms;
        wet_elapsed = i_in.now_ms - n_wet_start;
        dry_elapsed = i_in.now_ms - n_dry_start;

        n_latch   = r_latch;
        n_wet_run = r_wet_run;
        n_dry_run = r_dry_run;

        if (!r_latch) begin
            if (wet) begin
                n_wet_run = 1'b1;
                if (wet_elapsed >= {{(TIME_W-SUSTAIN_W){1'b0}}, i_cfg.trigger_sustain_ms}) begin
                    n_latch   = 1'b1;
                    n_dry_run = 1'b0;
                end
            end else begin
                n_wet_run = 1'b0;
            end
        end else begin
            if (!wet) begin
                n_dry_run = 1'b1;
                if (dry_elapsed >= {{(TIME_W-SUSTAIN_W){1'b0}}, i_cfg.clear_sustain_ms}) begin
                    n_latch   = 1'b0;
                    n_wet_run = 1'b0;
                end
            end else begin
                n_dry_run = 1'b0;
            end
        end

        strobing      = n_latch & ~i_in.low_volt_on;
        n_prev_strobe = strobing;

        o_res.latched  = n_latch;
        o_res.strobing = strobing;
        o_res.restore  = ~strobing & r_prev_strobe & ~i_in.low_volt_on;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_latch       <= 1'b0;
            r_wet_run     <= 1'b0;
            r_dry_run     <= 1'b0;
            r_prev_strobe <= 1'b0;
        end else if (i_en) begin
            r_latch       <= n_latch;
            r_wet_run     <= n_wet_run;
            r_dry_run     <= n_dry_run;
            r_prev_strobe <= n_prev_strobe;
        end
    end

    // Start times are only read while their running flag is set.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_wet_start <= n_wet_start;
            r_dry_start <= n_dry_start;
        end
    end

    `SFAL_ASSERT_IMP(a_latch_stops_dry, i_clk, i_rst_n, $rose(r_latch), !r_dry_run)
    `SFAL_ASSERT_IMP(a_clear_stops_wet, i_clk, i_rst_n, $fell(r_latch), !r_wet_run)
    `SFAL_ASSERT_NXT(a_hold_when_idle, i_clk, i_rst_n, !i_en,
                     $stable(r_latch) && $stable(r_prev_strobe))

endmodule

>>> sv/sfal_led.sv
// LED phase pipeline: now_ms modulo the strobe period by reciprocal
// multiplication, then compare with the on time. Depends on sfal_pkg.
module sfal_led #(
    parameter int STROBE_PERIOD  = sfal_pkg::STROBE_PERIOD_DEF,
    parameter int STROBE_ON_TIME = sfal_pkg::STROBE_ON_TIME_DEF
) (
    input  logic                          i_clk,
    input  sfal_pkg::t_pipe_adv           i_adv,
    input  logic [sfal_pkg::TIME_W-1:0]   i_now,
    output logic                          o_led_on
);
    import sfal_pkg::*;

    // The remainder before correction stays below twice the period.
    localparam int PW = $clog2(STROBE_PERIOD) + 1;
    localparam longint unsigned RECIP_L = (64'd1 << TIME_W) / STROBE_PERIOD;
    localparam logic [TIME_W-1:0] RECIP     = TIME_W'(RECIP_L);
    localparam logic [TIME_W-1:0] PERIOD_T  = TIME_W'(STROBE_PERIOD);
    localparam logic [PW-1:0]     PERIOD_P  = PW'(STROBE_PERIOD);
    localparam logic [PW-1:0]     ON_TIME_P = PW'(STROBE_ON_TIME);

    logic [TIME_W-1:0]   r_now1;
    logic [2*TIME_W-1:0] r_prod;
    logic [TIME_W-1:0]   r_now2;
    logic [TIME_W-1:0]   r_qp;

    logic [2*TIME_W-1:0] prod;
    logic [2*TIME_W-1:0] qp_full;
    logic [TIME_W-1:0]   diff;
    logic [PW-1:0]       rem;
    logic [PW-1:0]       rem_fix;

    // The estimated quotient is the true one or one less.
    assign prod    = {{TIME_W{1'b0}}, i_now} * {{TIME_W{1'b0}}, RECIP};
    assign qp_full = {{TIME_W{1'b0}}, r_prod[2*TIME_W-1:TIME_W]}
                     * {{TIME_W{1'b0}}, PERIOD_T};

    always_ff @(posedge i_clk) begin
        if (i_adv.s1) begin
            r_now1 <= i_now;
            r_prod <= prod;
        end
        if (i_adv.s2) begin
            r_now2 <= r_now1;
            r_qp   <= qp_full[TIME_W-1:0];
        end
    end

    always_comb begin
        diff     = r_now2 - r_qp;
        rem      = diff[PW-1:0];
        rem_fix  = (rem >= PERIOD_P) ? rem - PERIOD_P : rem;
        o_led_on = rem_fix < ON_TIME_P;
    end

endmodule

>>> sv/sustained_flood_alarm_latch_core.sv
// Top level of the sustained flood alarm latch: handshakes, stage valids
// and result register. Depends on sfal_pkg, sfal_cfg, sfal_latch, sfal_led, assert_macros.svh.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-------------------------------
//  in      | request   | i_in_valid / o_in_ready    | i_in_data   (t_in_item)
//  out     | result    | o_out_valid / i_out_ready  | o_out_data  (t_out_item)
//  cfg     | write     | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// One request per cycle is accepted while no stalled result holds the stages.
// The four stages are the input register, the reciprocal product, the
// quotient-times-period product and the result register.
// The alarm state is updated as a request leaves the input register.
// A stalled result holds only the stages behind it that are full.
// Reset clears all valids and the alarm state and restores the configuration defaults.
`include "assert_macros.svh"
module sustained_flood_alarm_latch_core #(
    parameter int STROBE_PERIOD  = sfal_pkg::STROBE_PERIOD_DEF,
    parameter int STROBE_ON_TIME = sfal_pkg::STROBE_ON_TIME_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  sfal_pkg::t_in_item                i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output sfal_pkg::t_out_item               o_out_data,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [sfal_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [sfal_pkg::SUSTAIN_W-1:0]    i_cfg_data
);
    import sfal_pkg::*;

    logic       r_v0;
    logic       r_v1;
    logic       r_v2;
    logic       r_out_valid;
    t_in_item   r_in;
    t_latch_res r_res1;
    t_latch_res r_res2;
    t_out_item  r_out;

    t_cfg       cfg;
    t_latch_res res;
    t_pipe_adv  adv;
    logic       adv3;
    logic       in_fire;
    logic       led_on;

    always_comb begin
        adv3       = r_v2 & (~r_out_valid | i_out_ready);
        adv.s2     = r_v1 & (~r_v2 | adv3);
        adv.s1     = r_v0 & (~r_v1 | adv.s2);
        o_in_ready = ~r_v0 | adv.s1;
        in_fire    = i_in_valid & o_in_ready;
    end

    sfal_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_cfg       (cfg)
    );

    sfal_latch u_latch (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv.s1),
        .i_in    (r_in),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    sfal_led #(
        .STROBE_PERIOD  (STROBE_PERIOD),
        .STROBE_ON_TIME (STROBE_ON_TIME)
    ) u_led (
        .i_clk    (i_clk),
        .i_adv    (adv),
        .i_now    (r_in.now_ms),
        .o_led_on (led_on)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0        <= 1'b0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_v0 <= 1'b1;
            end else if (adv.s1) begin
                r_v0 <= 1'b0;
            end
            if (adv.s1) begin
                r_v1 <= 1'b1;
            end else if (adv.s2) begin
                r_v1 <= 1'b0;
            end
            if (adv.s2) begin
                r_v2 <= 1'b1;
            end else if (adv3) begin
                r_v2 <= 1'b0;
            end
            if (adv3) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in <= i_in_data;
        end
        if (adv.s1) begin
            r_res1 <= res;
        end
        if (adv.s2) begin
            r_res2 <= r_res1;
        end
        if (adv3) begin
            r_out.flood_latched <= r_res2.latched;
            r_out.strobe_active <= r_res2.strobing;
            r_out.led_level     <= r_res2.strobing & led_on;
            r_out.restore_nav   <= r_res2.restore;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `SFAL_ASSERT_IMP(a_strobe_needs_latch, i_clk, i_rst_n,
                     o_out_valid && o_out_data.strobe_active, o_out_data.flood_latched)
    `SFAL_ASSERT_IMP(a_led_only_strobing, i_clk, i_rst_n,
                     o_out_valid && !o_out_data.strobe_active, !o_out_data.led_level)
    `SFAL_ASSERT_IMP(a_restore_not_strobing, i_clk, i_rst_n,
                     o_out_valid && o_out_data.restore_nav, !o_out_data.strobe_active)

endmodule
